>>> hdl/qphs_pkg.sv
// shared types and constants for the quadratic probe hash search block
package qphs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int M_W         = SLOT_W + 1;
  localparam int KEY_W       = 31;
  localparam int CFG_W       = 11;
  localparam int SLOT_IDX_W  = 10;
  localparam int PROBE_W     = 10;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(1024);
  localparam logic [KEY_W-1:0] EMPTY_KEY  = '0;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [KEY_W-1:0]      key_value;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [PROBE_W-1:0] probe_count;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_sts_t;

  typedef struct packed {
    logic load;
    logic step;
  } probe_ctl_t;

endpackage

>>> hdl/qphs_ram.sv
// generic single write port ram with registered read
module qphs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/qphs_mod.sv
// iterative key modulo table size unit, four quotient bits per cycle
module qphs_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qphs_pkg::KEY_W-1:0]  dividend,
  input  logic [qphs_pkg::M_W-1:0]    modulus,
  output qphs_pkg::mod_sts_t          sts,
  output logic [qphs_pkg::SLOT_W-1:0] rem
);
  import qphs_pkg::*;

  localparam int DIV_W     = ((KEY_W + 3) / 4) * 4;
  localparam int DIV_STEPS = DIV_W / 4;
  localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  function automatic logic [SLOT_W-1:0] step4(input logic [SLOT_W-1:0] r_in,
                                              input logic [3:0] nib,
                                              input logic [M_W-1:0] m);
    logic [SLOT_W-1:0] r;
    logic [SLOT_W:0]   t;
    r = r_in;
    for (int j = 3; j >= 0; j--) begin
      t = {r, nib[j]};
      if (t >= m) begin
        r = SLOT_W'(t - m);
      end else begin
        r = t[SLOT_W-1:0];
      end
    end
    return r;
  endfunction

  logic [DIV_W-1:0] shift;
  logic [CNT_W-1:0] cnt;
  logic [M_W-1:0]   m_hold;
  logic             busy;
  logic             done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift  <= DIV_W'(dividend);
      m_hold <= modulus;
      rem    <= '0;
    end else if (busy) begin
      rem   <= step4(rem, shift[DIV_W-1 -: 4], m_hold);
      shift <= shift << 4;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

>>> hdl/qphs_probe.sv
// incremental quadratic probe slot generator
module qphs_probe (
  input  logic                        clk,
  input  qphs_pkg::probe_ctl_t        ctl,
  input  logic [qphs_pkg::SLOT_W-1:0] home,
  input  logic [qphs_pkg::M_W-1:0]    modulus,
  output logic [qphs_pkg::SLOT_W-1:0] pos
);
  import qphs_pkg::*;

  logic [SLOT_W-1:0] delta;
  logic [SLOT_W:0]   pos_sum;
  logic [SLOT_W:0]   d_sum;
  logic [SLOT_W:0]   d_red;
  logic [SLOT_W-1:0] pos_next;
  logic [SLOT_W-1:0] delta_next;

  // pos tracks (home + i*i) mod m, delta tracks (2i + 1) mod m
  always_comb begin
    pos_sum = {1'b0, pos} + {1'b0, delta};
    if (pos_sum >= modulus) begin
      pos_next = SLOT_W'(pos_sum - modulus);
    end else begin
      pos_next = pos_sum[SLOT_W-1:0];
    end
    d_sum = {1'b0, delta} + (SLOT_W+1)'(2);
    if (d_sum >= modulus) begin
      d_red = d_sum - modulus;
    end else begin
      d_red = d_sum;
    end
    if (d_red >= modulus) begin
      delta_next = SLOT_W'(d_red - modulus);
    end else begin
      delta_next = d_red[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos   <= home;
      delta <= (modulus == M_W'(1)) ? '0 : SLOT_W'(1);
    end else if (ctl.step) begin
      pos   <= pos_next;
      delta <= delta_next;
    end
  end

endmodule

>>> hdl/quadratic_probe_hash_search.sv
// top level of the quadratic probe hash search block
// after reset every one of the 1024 key ram slots is cleared; inputs stall, config writes are taken
// a load is written to the ram as it is taken and the next word is accepted the cycle after
// a search runs the key modulo, then one ram read and one check per probe
// the probe loop waits on the registered ram read, the modulo runs the 4 bit per cycle divider
// a finished result sits in an output register while new words are accepted
module quadratic_probe_hash_search (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [qphs_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  qphs_pkg::in_word_t       in_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output qphs_pkg::out_word_t      out_word
);
  import qphs_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_CHECK = 5'b10000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CFG_W-1:0]  table_size;
  logic [SLOT_W-1:0] clr_cnt;
  logic [M_W-1:0]    m_eff;
  logic [M_W-1:0]    m_reg;
  logic [KEY_W-1:0]  key_reg;
  logic [SLOT_W-1:0] probe_i;
  logic              in_acc;
  logic              out_free;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;
  logic [KEY_W-1:0]  ram_rdata;
  logic              load_ok;
  logic              mod_start;
  mod_sts_t          mod_sts;
  logic [SLOT_W-1:0] mod_rem;
  probe_ctl_t        probe_ctl;
  logic [SLOT_W-1:0] pos;
  logic              hit;
  logic              empty;
  logic              last;
  logic              finish;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_ok  = (32'(in_word.slot_index) < TABLE_DEPTH);

  always_comb begin
    if (table_size == '0) begin
      m_eff = M_W'(1);
    end else if (32'(table_size) > TABLE_DEPTH) begin
      m_eff = M_W'(TABLE_DEPTH);
    end else begin
      m_eff = M_W'(table_size);
    end
  end

  assign hit    = (ram_rdata == key_reg);
  assign empty  = (ram_rdata == EMPTY_KEY);
  assign last   = ({1'b0, probe_i} == m_reg - M_W'(1));
  assign finish = (state == ST_CHECK) && (hit || empty || last) && out_free;

  assign mod_start = in_acc && (in_word.req_type == REQ_SEARCH);

  always_comb begin
    probe_ctl.load = (state == ST_DIV) && mod_sts.done;
    probe_ctl.step = (state == ST_CHECK) && !(hit || empty || last);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_word.slot_index[SLOT_W-1:0];
    ram_wdata = in_word.key_value;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = EMPTY_KEY;
    end else if (in_acc && (in_word.req_type == REQ_LOAD) && load_ok) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == SLOT_W'(TABLE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (mod_start) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_sts.done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (finish) begin
          state_next = ST_IDLE;
        end else if (probe_ctl.step) begin
          state_next = ST_READ;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      table_size <= SIZE_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_wr_en) begin
        table_size <= cfg_wr_data;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mod_start) begin
      key_reg <= in_word.key_value;
      m_reg   <= m_eff;
    end
    if (probe_ctl.load) begin
      probe_i <= '0;
    end else if (probe_ctl.step) begin
      probe_i <= probe_i + 1'b1;
    end
    if (finish) begin
      out_word.found       <= hit;
      out_word.probe_count <= hit ? PROBE_W'(probe_i) : '0;
    end
  end

  qphs_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (in_word.key_value),
    .modulus  (m_eff),
    .sts      (mod_sts),
    .rem      (mod_rem)
  );

  qphs_probe u_probe (
    .clk     (clk),
    .ctl     (probe_ctl),
    .home    (mod_rem),
    .modulus (m_reg),
    .pos     (pos)
  );

  qphs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  a_ram_wr_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_IDLE))
    else $error("ram written outside clear or idle");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_CHECK) |-> ({1'b0, pos} < m_reg))
    else $error("probe slot beyond table size");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> ({1'b0, probe_i} < m_reg))
    else $error("probe number beyond table size");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && mod_sts.done) |-> ({1'b0, mod_rem} < m_reg))
    else $error("home slot beyond table size");

  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid && (state == ST_IDLE))
    else $error("finished search did not post a result");
`endif

endmodule

>>> sim/quadratic_probe_hash_search_tb.sv
// self-checking testbench for quadratic_probe_hash_search: loads, lookups and size settings
`timescale 1ns / 100ps

module quadratic_probe_hash_search_tb;
  import qphs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 40;

  logic clk;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  in_word_t request_queue[$];
  out_word_t expected_lookups[$];
  logic [KEY_W-1:0] key_store [TABLE_DEPTH] = '{default: '0};
  logic [KEY_W-1:0] plan_store [TABLE_DEPTH] = '{default: '0};
  logic [KEY_W-1:0] placed_keys[$];
  logic [CFG_W-1:0] size_reg = SIZE_RESET;
  logic word_taken = 1'b0;
  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  quadratic_probe_hash_search u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int unsigned live_size(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(v);
  endfunction

  // updates the key store on a load, works out the lookup outcome on a search
  function automatic void resolve_request(in_word_t w);
    int unsigned m, home, i, slot;
    out_word_t hit;
    if (w.req_type == REQ_LOAD) begin
      key_store[w.slot_index] = w.key_value;
      return;
    end
    m = live_size(size_reg);
    home = w.key_value % m;
    hit = '0;
    for (i = 0; i < m; i++) begin
      slot = (home + i * i) % m;
      if (key_store[slot] == w.key_value) begin
        hit.found = 1'b1;
        hit.probe_count = PROBE_W'(i);
        break;
      end
      if (key_store[slot] == EMPTY_KEY) break;
    end
    expected_lookups.push_back(hit);
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_result(out_word_t got);
    out_word_t want;
    if (expected_lookups.size() == 0) begin
      note_error($sformatf("result word with nothing outstanding: found=%0d probe=%0d",
                           got.found, got.probe_count));
      return;
    end
    want = expected_lookups.pop_front();
    if (got.found !== want.found || got.probe_count !== want.probe_count)
      note_error($sformatf("lookup mismatch: expected found=%0d probe=%0d, got found=%0d probe=%0d",
                           want.found, want.probe_count, got.found, got.probe_count));
  endfunction

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) resolve_request(in_word);
      if (out_valid && !out_stall) check_result(out_word);
    end
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** quadratic_probe_hash_search: FAILED **");
      $finish;
    end
  end

  // driver
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_word <= request_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(3))
      0: k = KEY_W'($urandom_range(1, 200));
      1: k = KEY_W'($urandom);
      2: k = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 200));
      default: k = KEY_W'(1) << $urandom_range(KEY_W - 1);
    endcase
    if (k == EMPTY_KEY) k = KEY_W'(1);
    return k;
  endfunction

  task automatic queue_load(int unsigned slot, logic [KEY_W-1:0] k);
    in_word_t w;
    w.req_type = REQ_LOAD;
    w.slot_index = SLOT_IDX_W'(slot);
    w.key_value = k;
    plan_store[w.slot_index] = k;
    request_queue.push_back(w);
  endtask

  task automatic queue_search(logic [KEY_W-1:0] k);
    in_word_t w;
    w.req_type = REQ_SEARCH;
    w.slot_index = SLOT_IDX_W'($urandom);
    w.key_value = k;
    request_queue.push_back(w);
  endtask

  // places a key at the first empty slot along its probe path, or at a random slot if none is empty
  task automatic add_insert(logic [KEY_W-1:0] k);
    int unsigned m, home, i, slot;
    m = live_size(size_reg);
    home = k % m;
    placed_keys.push_back(k);
    for (i = 0; i < m; i++) begin
      slot = (home + i * i) % m;
      if (plan_store[slot] == EMPTY_KEY) begin
        queue_load(slot, k);
        return;
      end
    end
    queue_load($urandom_range(m - 1), k);
  endtask

  task automatic wait_idle();
    while (request_queue.size() != 0 || in_valid || expected_lookups.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_size(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    size_reg = v;
  endtask

  task automatic random_phase(logic [CFG_W-1:0] size_val, int idle, int stall, int count,
                              bit pause_mid);
    int n, pick;
    int unsigned m;
    set_size(size_val);
    idle_pct = idle;
    stall_pct = stall;
    m = live_size(size_val);
    for (n = 0; n < count; n++) begin
      if (pause_mid && n == count / 2) wait_idle();
      pick = $urandom_range(99);
      if (pick < 35) add_insert(rand_key());
      else if (pick < 70 && placed_keys.size() != 0)
        queue_search(placed_keys[$urandom_range(placed_keys.size() - 1)]);
      else if (pick < 80) queue_search(rand_key());
      else if (pick < 85) queue_search(EMPTY_KEY);
      else if (pick < 90) queue_load($urandom_range(m - 1), EMPTY_KEY);
      else queue_load($urandom_range(TABLE_DEPTH - 1), rand_key());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset size, empty store
    queue_search(KEY_W'(5));
    queue_search(EMPTY_KEY);
    queue_load(TABLE_DEPTH - 1, {KEY_W{1'b1}});
    queue_search({KEY_W{1'b1}});
    queue_load(0, KEY_W'(1024));
    queue_load(1, KEY_W'(2048));
    queue_search(KEY_W'(2048));
    queue_search(KEY_W'(3072));
    queue_load(5, KEY_W'(1029));

    // size zero acts as one slot
    set_size('0);
    queue_load(0, KEY_W'(7));
    queue_search(KEY_W'(7));
    queue_search(KEY_W'(9));
    queue_search(EMPTY_KEY);

    // oversize clamps to full depth, slot loaded earlier becomes visible
    set_size({CFG_W{1'b1}});
    queue_search(KEY_W'(1029));
    queue_search(KEY_W'(7));

    // full two-slot table
    set_size(CFG_W'(2));
    queue_load(1, KEY_W'(3));
    queue_search(KEY_W'(4));
    queue_search(KEY_W'(3));
    queue_search(EMPTY_KEY);
    queue_search(KEY_W'(9));

    random_phase(CFG_W'($urandom_range(3, 16)), 0, 0, 80, 1'b0);
    random_phase(SIZE_RESET, 73, 0, 80, 1'b0);
    random_phase(CFG_W'($urandom_range(17, 64)), 0, 73, 80, 1'b0);
    random_phase(CFG_W'($urandom_range(2, 12)), 29, 29, 80, 1'b1);
    random_phase(CFG_W'($urandom_range(0, 2047)), 0, 0, 80, 1'b0);

    wait_idle();
    if (error_count == 0) begin
      $display("** quadratic_probe_hash_search: PASSED **");
    end else begin
      $display("** quadratic_probe_hash_search: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/qphs_pkg.sv
hdl/qphs_ram.sv
hdl/qphs_mod.sv
hdl/qphs_probe.sv
hdl/quadratic_probe_hash_search.sv
sim/quadratic_probe_hash_search_tb.sv
